### rtl/core/cse_pkg.sv
// Shared types, codes and calendar helpers for the set-mode editor.
package cse_pkg;

  // Cursor positions.
  localparam logic [2:0] POS_DAY     = 3'd0;
  localparam logic [2:0] POS_MONTH   = 3'd1;
  localparam logic [2:0] POS_YEAR    = 3'd2;
  localparam logic [2:0] POS_WEEKDAY = 3'd3;
  localparam logic [2:0] POS_HOUR    = 3'd4;
  localparam logic [2:0] POS_MINUTE  = 3'd5;
  localparam logic [2:0] POS_OK      = 3'd6;

  // Navigation codes.
  localparam logic [1:0] NAV_NONE   = 2'd0;
  localparam logic [1:0] NAV_LEFT   = 2'd1;
  localparam logic [1:0] NAV_RIGHT  = 2'd2;
  localparam logic [1:0] NAV_CENTER = 2'd3;

  // Value-change codes.
  localparam logic [1:0] CHG_NONE   = 2'd0;
  localparam logic [1:0] CHG_UP     = 2'd1;
  localparam logic [1:0] CHG_DOWN   = 2'd2;
  localparam logic [1:0] CHG_CENTER = 2'd3;

  localparam logic [11:0] YEAR_MIN   = 12'd2000;
  localparam logic [11:0] YEAR_MAX   = 12'd2100;
  localparam logic [11:0] YEAR_RESET = 12'd2025;

  localparam logic [3:0] MONTH_LAST   = 4'd12;
  localparam logic [2:0] WEEKDAY_LAST = 3'd6;
  localparam logic [4:0] HOUR_LAST    = 5'd23;
  localparam logic [5:0] MINUTE_LAST  = 6'd59;

  typedef struct packed {
    logic [1:0] nav_code;
    logic [1:0] change_code;
    logic       exit_button;
  } cse_cmd_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  cursor;
    logic        done;
  } cse_state_t;

  // The year never leaves 2000..2100, so within that span the only
  // century year that is not a leap year is 2100.
  function automatic logic is_leap(input logic [11:0] year);
    return (year[1:0] == 2'd0) && (year != YEAR_MAX);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month,
                                           input logic [11:0] year);
    logic [4:0] len;
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = is_leap(year) ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/cse_in_stage.sv
// Input register stage of the set-mode editor.
module cse_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        nav_code,
  input  logic [1:0]        change_code,
  input  logic              exit_button,
  input  logic              advance,
  output logic              cmd_valid,
  output cse_pkg::cse_cmd_t cmd
);

  logic ready;

  // The stage takes a new request when it is empty or its request moves on.
  assign ready    = !cmd_valid || advance;
  assign in_stall = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      cmd.nav_code    <= nav_code;
      cmd.change_code <= change_code;
      cmd.exit_button <= exit_button;
    end
  end

endmodule

### rtl/core/cse_edit.sv
// Next-state logic of the set-mode editor: navigation, field edit, commit.
module cse_edit (
  input  cse_pkg::cse_state_t state,
  input  cse_pkg::cse_cmd_t   cmd,
  output cse_pkg::cse_state_t state_next,
  output logic                commit
);

  logic       up;
  logic       dn;
  logic [2:0] cur;
  logic [4:0] lim;

  assign up = (cmd.change_code == cse_pkg::CHG_UP);
  assign dn = (cmd.change_code == cse_pkg::CHG_DOWN);

  always_comb begin
    state_next = state;
    commit     = 1'b0;
    cur        = state.cursor;
    lim        = 5'd31;

    if (!state.done) begin
      // Navigation first, saturating at both ends.
      if (cmd.nav_code == cse_pkg::NAV_LEFT && state.cursor != cse_pkg::POS_DAY) begin
        cur = state.cursor - 3'd1;
      end else if (cmd.nav_code == cse_pkg::NAV_RIGHT && state.cursor != cse_pkg::POS_OK) begin
        cur = state.cursor + 3'd1;
      end
      state_next.cursor = cur;

      case (cur)
        cse_pkg::POS_DAY: begin
          lim = cse_pkg::month_len(state.month, state.year);
          if (up) begin
            state_next.day = (state.day >= lim) ? 5'd1 : state.day + 5'd1;
          end else if (dn) begin
            state_next.day = (state.day <= 5'd1) ? lim : state.day - 5'd1;
          end
        end
        cse_pkg::POS_MONTH: begin
          if (up) begin
            state_next.month = (state.month >= cse_pkg::MONTH_LAST) ? 4'd1
                                                                    : state.month + 4'd1;
          end else if (dn) begin
            state_next.month = (state.month <= 4'd1) ? cse_pkg::MONTH_LAST
                                                     : state.month - 4'd1;
          end
          lim = cse_pkg::month_len(state_next.month, state.year);
          if ((up || dn) && state.day > lim) begin
            state_next.day = lim;
          end
        end
        cse_pkg::POS_YEAR: begin
          if (up) begin
            state_next.year = (state.year >= cse_pkg::YEAR_MAX) ? cse_pkg::YEAR_MAX
                                                                : state.year + 12'd1;
          end else if (dn) begin
            state_next.year = (state.year <= cse_pkg::YEAR_MIN) ? cse_pkg::YEAR_MIN
                                                                : state.year - 12'd1;
          end
          lim = cse_pkg::month_len(state.month, state_next.year);
          if ((up || dn) && state.day > lim) begin
            state_next.day = lim;
          end
        end
        cse_pkg::POS_WEEKDAY: begin
          if (up) begin
            state_next.weekday = (state.weekday >= cse_pkg::WEEKDAY_LAST) ? 3'd0
                                                                          : state.weekday + 3'd1;
          end else if (dn) begin
            state_next.weekday = (state.weekday == 3'd0) ? cse_pkg::WEEKDAY_LAST
                                                         : state.weekday - 3'd1;
          end
        end
        cse_pkg::POS_HOUR: begin
          if (up) begin
            state_next.hour = (state.hour >= cse_pkg::HOUR_LAST) ? 5'd0 : state.hour + 5'd1;
          end else if (dn) begin
            state_next.hour = (state.hour == 5'd0) ? cse_pkg::HOUR_LAST : state.hour - 5'd1;
          end
        end
        cse_pkg::POS_MINUTE: begin
          if (up) begin
            state_next.minute = (state.minute >= cse_pkg::MINUTE_LAST) ? 6'd0
                                                                       : state.minute + 6'd1;
          end else if (dn) begin
            state_next.minute = (state.minute == 6'd0) ? cse_pkg::MINUTE_LAST
                                                       : state.minute - 6'd1;
          end
        end
        default: begin
          // OK position: a centre press on either control commits.
          commit = (cmd.change_code == cse_pkg::CHG_CENTER) ||
                   (cmd.nav_code == cse_pkg::NAV_CENTER);
        end
      endcase

      if (cmd.exit_button) begin
        commit = 1'b1;
      end
      if (commit) begin
        state_next.done = 1'b1;
      end
    end
  end

endmodule

### rtl/core/calendar_set_mode_editor.sv
// Top level of the watch-style date and time set-mode editor.
// The editor takes one request per clock cycle while neither side stalls, and
// returns exactly one result for each request. The request is held in the
// input register while the combinational edit logic works on it, and its
// result then loads the result register, where it waits until it is taken.
// The edit logic updates the held date, time, cursor and finished state.
// Each request first moves the cursor (left and right saturate at day and
// OK), then edits the selected field: day, month, weekday, hour and minute
// wrap, the year saturates between 2000 and 2100, and the day is clamped
// whenever the month or year changes. A centre press on OK, or the exit
// button, raises commit_pulse for that result and sets finished_flag; every
// later request returns the held values unchanged until reset. Stall on the
// result side holds the result register and, once the input register is
// also full, stalls the request side; nothing is lost or repeated.
module calendar_set_mode_editor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  nav_code,
  input  logic [1:0]  change_code,
  input  logic        exit_button,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  day_value,
  output logic [3:0]  month_value,
  output logic [11:0] year_value,
  output logic [2:0]  weekday_value,
  output logic [4:0]  hour_value,
  output logic [5:0]  minute_value,
  output logic [2:0]  cursor_pos,
  output logic        commit_pulse,
  output logic        finished_flag
);

  logic                out_ready;
  logic                cmd_valid;
  cse_pkg::cse_cmd_t   cmd;
  cse_pkg::cse_state_t state;
  cse_pkg::cse_state_t state_next;
  logic                commit;

  // The result register can take a new result when it is empty or when
  // its current result is being taken in this cycle.
  assign out_ready = !out_valid || !out_stall;

  cse_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .nav_code    (nav_code),
    .change_code (change_code),
    .exit_button (exit_button),
    .advance     (out_ready),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd)
  );

  cse_edit u_edit (
    .state      (state),
    .cmd        (cmd),
    .state_next (state_next),
    .commit     (commit)
  );

  // The editor state advances only when a request moves into the result
  // register, so results keep the order of requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.day     <= 5'd1;
      state.month   <= 4'd1;
      state.year    <= cse_pkg::YEAR_RESET;
      state.weekday <= 3'd0;
      state.hour    <= 5'd0;
      state.minute  <= 6'd0;
      state.cursor  <= cse_pkg::POS_DAY;
      state.done    <= 1'b0;
    end else if (out_ready && cmd_valid) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= cmd_valid;
    end
  end

  // Result payload; it needs no reset as out_valid qualifies it.
  always_ff @(posedge clk) begin
    if (out_ready && cmd_valid) begin
      day_value     <= state_next.day;
      month_value   <= state_next.month;
      year_value    <= state_next.year;
      weekday_value <= state_next.weekday;
      hour_value    <= state_next.hour;
      minute_value  <= state_next.minute;
      cursor_pos    <= state_next.cursor;
      commit_pulse  <= commit;
      finished_flag <= state_next.done;
    end
  end

  // A committed result always reports the editor as finished.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && commit_pulse |-> finished_flag)
    else $error("commit result without finished flag");

  // Once finished, the whole editor state is frozen until reset.
  assert property (@(posedge clk) disable iff (rst)
                   state.done |=> $stable(state))
    else $error("editor state changed after finishing");

  // The year never leaves its saturating range.
  assert property (@(posedge clk) disable iff (rst)
                   state.year >= cse_pkg::YEAR_MIN && state.year <= cse_pkg::YEAR_MAX)
    else $error("year out of range");

  // The day never exceeds the length of the current month.
  assert property (@(posedge clk) disable iff (rst)
                   state.day >= 5'd1 &&
                   state.day <= cse_pkg::month_len(state.month, state.year))
    else $error("day outside current month");

endmodule

### sim/cse_editor_scoreboard_pkg.sv
// Expected-result tracking and calendar prediction for the set-mode editor testbench.
package cse_editor_scoreboard_pkg;

  import cse_pkg::*;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  cursor;
    logic        commit;
    logic        finished;
  } editor_view_t;

  class editor_scoreboard;
    logic [2:0]   cursor;
    logic [4:0]   day;
    logic [3:0]   month;
    logic [11:0]  year;
    logic [2:0]   weekday;
    logic [4:0]   hour;
    logic [5:0]   minute;
    logic         done;
    editor_view_t pending[$];
    int           errors;
    int           requests;
    int           results;

    function new();
      cursor   = POS_DAY;
      day      = 5'd1;
      month    = 4'd1;
      year     = YEAR_RESET;
      weekday  = 3'd0;
      hour     = 5'd0;
      minute   = 6'd0;
      done     = 1'b0;
      errors   = 0;
      requests = 0;
      results  = 0;
    endfunction

    // Full Gregorian rule, so the 2000 and 2100 corners are worked out independently.
    function logic [4:0] days_in_month(input logic [3:0] m, input logic [11:0] y);
      logic leap;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      case (m)
        4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
        4'd2:                    return leap ? 5'd29 : 5'd28;
        default:                 return 5'd31;
      endcase
    endfunction

    function void clamp_day();
      logic [4:0] lim;
      lim = days_in_month(month, year);
      if (day > lim) day = lim;
    endfunction

    function void note_request(input logic [1:0] nav, input logic [1:0] chg,
                               input logic ext);
      editor_view_t view;
      logic         commit;
      logic [4:0]   lim;
      commit = 1'b0;
      if (!done) begin
        if (nav == NAV_LEFT && cursor != POS_DAY) cursor = cursor - 3'd1;
        else if (nav == NAV_RIGHT && cursor != POS_OK) cursor = cursor + 3'd1;
        case (cursor)
          POS_DAY: begin
            lim = days_in_month(month, year);
            if (chg == CHG_UP) day = (day >= lim) ? 5'd1 : day + 5'd1;
            else if (chg == CHG_DOWN) day = (day <= 5'd1) ? lim : day - 5'd1;
          end
          POS_MONTH: begin
            if (chg == CHG_UP) month = (month >= MONTH_LAST) ? 4'd1 : month + 4'd1;
            else if (chg == CHG_DOWN) month = (month <= 4'd1) ? MONTH_LAST : month - 4'd1;
            if (chg == CHG_UP || chg == CHG_DOWN) clamp_day();
          end
          POS_YEAR: begin
            if (chg == CHG_UP) year = (year >= YEAR_MAX) ? YEAR_MAX : year + 12'd1;
            else if (chg == CHG_DOWN) year = (year <= YEAR_MIN) ? YEAR_MIN : year - 12'd1;
            if (chg == CHG_UP || chg == CHG_DOWN) clamp_day();
          end
          POS_WEEKDAY: begin
            if (chg == CHG_UP) weekday = (weekday >= WEEKDAY_LAST) ? 3'd0 : weekday + 3'd1;
            else if (chg == CHG_DOWN) weekday = (weekday == 3'd0) ? WEEKDAY_LAST : weekday - 3'd1;
          end
          POS_HOUR: begin
            if (chg == CHG_UP) hour = (hour >= HOUR_LAST) ? 5'd0 : hour + 5'd1;
            else if (chg == CHG_DOWN) hour = (hour == 5'd0) ? HOUR_LAST : hour - 5'd1;
          end
          POS_MINUTE: begin
            if (chg == CHG_UP) minute = (minute >= MINUTE_LAST) ? 6'd0 : minute + 6'd1;
            else if (chg == CHG_DOWN) minute = (minute == 6'd0) ? MINUTE_LAST : minute - 6'd1;
          end
          default: begin
            if (chg == CHG_CENTER || nav == NAV_CENTER) commit = 1'b1;
          end
        endcase
        if (ext) commit = 1'b1;
        if (commit) done = 1'b1;
      end
      view.day      = day;
      view.month    = month;
      view.year     = year;
      view.weekday  = weekday;
      view.hour     = hour;
      view.minute   = minute;
      view.cursor   = cursor;
      view.commit   = commit;
      view.finished = done;
      pending.push_back(view);
      requests++;
    endfunction

    function void compare_field(input string name, input int unsigned want,
                                input int unsigned got, input time stamp);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", stamp, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input time stamp, input editor_view_t got);
      editor_view_t want;
      if (pending.size() == 0) begin
        $display("%0t: result arrived with no request outstanding", stamp);
        errors++;
        return;
      end
      want = pending.pop_front();
      results++;
      compare_field("day_value", 32'(want.day), 32'(got.day), stamp);
      compare_field("month_value", 32'(want.month), 32'(got.month), stamp);
      compare_field("year_value", 32'(want.year), 32'(got.year), stamp);
      compare_field("weekday_value", 32'(want.weekday), 32'(got.weekday), stamp);
      compare_field("hour_value", 32'(want.hour), 32'(got.hour), stamp);
      compare_field("minute_value", 32'(want.minute), 32'(got.minute), stamp);
      compare_field("cursor_pos", 32'(want.cursor), 32'(got.cursor), stamp);
      compare_field("commit_pulse", 32'(want.commit), 32'(got.commit), stamp);
      compare_field("finished_flag", 32'(want.finished), 32'(got.finished), stamp);
    endfunction
  endclass

endpackage

### sim/tb_calendar_set_mode_editor.sv
// Self-checking testbench for the calendar set-mode editor.
module tb_calendar_set_mode_editor;
  timeunit 1ns;
  timeprecision 1ps;

  import cse_pkg::*;
  import cse_editor_scoreboard_pkg::*;

  // A run with no handshake on either side for this many cycles is treated as hung.
  // Each side idles with a chance of at most 79 in a hundred, so a quiet stretch this
  // long is practically impossible in a correct run.
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  nav_code;
  logic [1:0]  change_code;
  logic        exit_button;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  day_value;
  logic [3:0]  month_value;
  logic [11:0] year_value;
  logic [2:0]  weekday_value;
  logic [4:0]  hour_value;
  logic [5:0]  minute_value;
  logic [2:0]  cursor_pos;
  logic        commit_pulse;
  logic        finished_flag;

  // Idling rates in percent; the stimulus process changes them between phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  string commit_form = "none";

  editor_scoreboard sb = new();

  calendar_set_mode_editor dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .nav_code      (nav_code),
    .change_code   (change_code),
    .exit_button   (exit_button),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .day_value     (day_value),
    .month_value   (month_value),
    .year_value    (year_value),
    .weekday_value (weekday_value),
    .hour_value    (hour_value),
    .minute_value  (minute_value),
    .cursor_pos    (cursor_pos),
    .commit_pulse  (commit_pulse),
    .finished_flag (finished_flag)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Presents one request, holds it steady until the editor takes it, then hands it
  // to the scoreboard. Signals are read at the clock edge, so in_stall is the value
  // that held just before the edge. A random idle gap may come first.
  task automatic send_request(input logic [1:0] nav, input logic [1:0] chg,
                              input logic ext);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    nav_code    <= nav;
    change_code <= chg;
    exit_button <= ext;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(nav, chg, ext);
  endtask

  // A short walk from the reset state through every field, touching each wrap,
  // the saturating cursor ends, the clamp of the day on month and year changes,
  // and centre presses that must edit nothing.
  task automatic run_directed();
    send_request(NAV_LEFT,   CHG_DOWN,   1'b0); // cursor held at day; day wraps down to 31
    send_request(NAV_CENTER, CHG_CENTER, 1'b0); // centre presses away from OK do nothing
    send_request(NAV_RIGHT,  CHG_DOWN,   1'b0); // month wraps down to December
    send_request(NAV_NONE,   CHG_UP,     1'b0); // and back up to January
    send_request(NAV_NONE,   CHG_UP,     1'b0); // February 2025 clamps day 31 to 28
    send_request(NAV_RIGHT,  CHG_DOWN,   1'b0); // 2024 is a leap year
    send_request(NAV_LEFT,   CHG_NONE,   1'b0);
    send_request(NAV_LEFT,   CHG_UP,     1'b0); // day 29 exists in February 2024
    send_request(NAV_RIGHT,  CHG_NONE,   1'b0);
    send_request(NAV_RIGHT,  CHG_UP,     1'b0); // back to 2025: day clamps to 28
    send_request(NAV_RIGHT,  CHG_DOWN,   1'b0); // weekday wraps down to Saturday
    send_request(NAV_NONE,   CHG_UP,     1'b0); // and up to Sunday
    send_request(NAV_RIGHT,  CHG_DOWN,   1'b0); // hour wraps down to 23
    send_request(NAV_NONE,   CHG_UP,     1'b0); // and up to 0
    send_request(NAV_RIGHT,  CHG_DOWN,   1'b0); // minute wraps down to 59
    send_request(NAV_NONE,   CHG_UP,     1'b0); // and up to 0
    send_request(NAV_NONE,   CHG_CENTER, 1'b0); // centre change on a value field
    send_request(NAV_RIGHT,  CHG_NONE,   1'b0); // onto OK
    send_request(NAV_RIGHT,  CHG_UP,     1'b0); // cursor saturates at OK; up edits nothing
    send_request(NAV_LEFT,   CHG_DOWN,   1'b0); // back to minute, which wraps to 59
  endtask

  // Random editing that never finishes the editor, since only reset would undo that.
  // A quarter of the time a burst of the same change is sent to the current field,
  // so that wraps, month-end clamps and both year limits are actually reached.
  task automatic edit_randomly(input int count);
    int         sent;
    int         run_len;
    logic [1:0] nav;
    logic [1:0] chg;
    logic [2:0] next_pos;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(3) == 0) begin
        chg     = $urandom_range(1) ? CHG_UP : CHG_DOWN;
        run_len = (sb.cursor == POS_YEAR) ? $urandom_range(20, 80) : $urandom_range(3, 35);
        repeat (run_len) send_request(NAV_NONE, chg, 1'b0);
        sent += run_len;
      end else begin
        nav      = 2'($urandom_range(3));
        chg      = 2'($urandom_range(3));
        next_pos = sb.cursor;
        if (nav == NAV_LEFT && next_pos != POS_DAY) next_pos = next_pos - 3'd1;
        else if (nav == NAV_RIGHT && next_pos != POS_OK) next_pos = next_pos + 3'd1;
        // A centre press that would land on OK is turned into a harmless request.
        if (next_pos == POS_OK && nav == NAV_CENTER) nav = NAV_LEFT;
        else if (next_pos == POS_OK && chg == CHG_CENTER) chg = CHG_DOWN;
        send_request(nav, chg, 1'b0);
        sent++;
      end
    end
  endtask

  // Walks to OK and commits in one of four ways chosen at random, then sends a few
  // requests that the finished editor must ignore, with the exit button toggling.
  task automatic finish_editing();
    while (sb.cursor != POS_OK) send_request(NAV_RIGHT, CHG_NONE, 1'b0);
    case ($urandom_range(3))
      0: begin
        commit_form = "the exit button alone";
        send_request(NAV_NONE, CHG_UP, 1'b1);
      end
      1: begin
        commit_form = "a navigation centre press on OK";
        send_request(NAV_CENTER, CHG_NONE, 1'b0);
      end
      2: begin
        commit_form = "a change centre press on OK";
        send_request(NAV_NONE, CHG_CENTER, 1'b0);
      end
      default: begin
        commit_form = "centre presses and the exit button together";
        send_request(NAV_CENTER, CHG_CENTER, 1'b1);
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      send_request(2'($urandom_range(3)), 2'($urandom_range(3)), i[0]);
    end
  endtask

  // Result side: check every accepted result, then pick the stall for the next cycle.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_result($time, {day_value, month_value, year_value, weekday_value,
                                hour_value, minute_value, cursor_pos, commit_pulse,
                                finished_flag});
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Ends a hung run: counts cycles in which neither side completes a handshake.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Main sequence: reset once, directed walk, three idling phases of random editing,
  // the commit, and a drain before the verdict.
  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    nav_code    <= NAV_NONE;
    change_code <= CHG_NONE;
    exit_button <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // First phase: the sender is nearly always ready, the receiver mostly stalls.
    send_idle_pct  = 6;
    recv_stall_pct = 79;
    run_directed();
    edit_randomly(175);

    // Second phase: the other way round.
    send_idle_pct  = 79;
    recv_stall_pct = 6;
    edit_randomly(175);

    // Third phase: back-to-back requests with no stalls at all.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    edit_randomly(175);

    finish_editing();
    in_valid <= 1'b0;

    // Wait for every outstanding result, then keep checking for any stray one.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d requests and checked %0d results over three idling phases,",
             sb.requests, sb.results);
    $display("finishing the edit with %s.", commit_form);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
